// ----- hdl/bagb_pkg.sv -----
// ----------------------------------------------------------------------------
// bagb_pkg: shared definitions for the bit-aligned glyph blitter
// Frame buffer size, address widths, register indexes, operation and
// status codes, and the controller state type.
// ----------------------------------------------------------------------------
package bagb_pkg;

    // Frame buffer geometry.
    localparam int FB_BYTES = 8192;
    localparam int FB_AW    = $clog2(FB_BYTES);

    // Width of the computed byte address before the range check. The largest
    // value is green base plus (255 + 254) * 511 + 255 + 31 + 1, below 2^19.
    localparam int CALC_W = 20;

    // Configuration register indexes.
    localparam logic REG_STRIDE     = 1'b0;
    localparam logic REG_GREEN_BASE = 1'b1;

    // Configuration reset values.
    localparam logic [8:0]  STRIDE_RESET     = 9'd16;
    localparam logic [12:0] GREEN_BASE_RESET = 13'd4096;

    // Operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    // Controller states.
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_ADDR  = 6'b001000,
        S_RMW   = 6'b010000,
        S_DRAIN = 6'b100000
    } state_t;

endpackage

// ----- hdl/bagb_ram.sv -----
// ----------------------------------------------------------------------------
// bagb_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and returns
// the old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module bagb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/bit_aligned_glyph_blit.sv -----
// ----------------------------------------------------------------------------
// bit_aligned_glyph_blit: masked 1-bpp glyph writer for a two-plane buffer
// Writes glyph bytes at any pixel position into a byte-packed red/green
// frame buffer by masked read-modify-write, and reads buffer bytes back.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken at a clock edge where start is high and
// busy is low. op selects start glyph, glyph data byte or buffer read. Every
// command gives exactly one result beat: read_data, glyph_done and status
// are valid for the single cycle in which result_strobe is high. The
// receiver cannot stall, so it must take each result in that cycle.
// Timing: a start command, a data byte with no glyph in progress or the
// unused code answers in the next cycle and leaves busy low, so the next
// command may follow straight away. A read passes through the S_READ state
// before its result is registered. A data byte for a glyph in progress
// keeps busy high through S_ADDR, the four read-modify-write slots of S_RMW
// (two bytes in two planes, sharing the single read port of the frame
// buffer RAM) and the write drain in S_DRAIN, then answers; no new command
// is taken until it is through.
// Reset: the control registers take their reset values at once, then a
// clearing pass writes zero to every buffer byte (FB_BYTES, 8192 by
// default), one per cycle, with busy high. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and are accepted at any time.
// ----------------------------------------------------------------------------
module bit_aligned_glyph_blit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [10:0] pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  glyph_width,
    input  logic [7:0]  glyph_height,
    input  logic [1:0]  color_planes,
    input  logic [7:0]  glyph_byte,
    input  logic [12:0] read_address,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output logic        result_strobe,
    output logic [7:0]  read_data,
    output logic        glyph_done,
    output logic [1:0]  status
);

    import bagb_pkg::*;

    // Controller and configuration registers.
    state_t              state_reg, state_next;
    logic [8:0]          stride_reg;
    logic [12:0]         green_base_reg;
    logic [FB_AW-1:0]    clr_reg, clr_next;

    // Glyph state.
    logic [10:0]         gx_reg, gx_next;
    logic [7:0]          gy_reg, gy_next;
    logic [7:0]          gw_reg, gw_next;
    logic [7:0]          gh_reg, gh_next;
    logic [1:0]          planes_reg, planes_next;
    logic [7:0]          row_reg, row_next;
    logic [4:0]          bcnt_reg, bcnt_next;
    logic                active_reg, active_next;

    // Per-byte working registers.
    logic [17:0]         prod_reg, prod_next;
    logic [15:0]         data16_reg, data16_next;
    logic [15:0]         mask16_reg, mask16_next;
    logic [CALC_W-1:0]   off_reg, off_next;
    logic [1:0]          idx_reg, idx_next;
    logic                err_reg, err_next;
    logic                rd_ok_reg, rd_ok_next;

    // Read-modify-write pipeline: pending write and last write for forwarding.
    logic                pend_valid_reg, pend_valid_next;
    logic [FB_AW-1:0]    pend_addr_reg, pend_addr_next;
    logic [7:0]          pend_data_reg, pend_data_next;
    logic [7:0]          pend_mask_reg, pend_mask_next;
    logic                lw_valid_reg;
    logic [FB_AW-1:0]    lw_addr_reg;
    logic [7:0]          lw_data_reg;

    // Result registers.
    logic                strobe_reg, strobe_next;
    logic [7:0]          rdata_out_reg, rdata_out_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;

    // RAM ports.
    logic                ram_we;
    logic [FB_AW-1:0]    ram_waddr;
    logic [7:0]          ram_wdata;
    logic [FB_AW-1:0]    ram_raddr;
    logic [7:0]          ram_rdata;

    // Combinational helpers.
    logic                accept;
    logic [8:0]          ysum;
    logic [17:0]         prod;
    logic [7:0]          left;
    logic [7:0]          gmask;
    logic [7:0]          dmasked;
    logic [CALC_W-1:0]   tgt_base;
    logic [CALC_W-1:0]   tgt_addr;
    logic [7:0]          tgt_mask;
    logic [7:0]          tgt_data;
    logic                tgt_en;
    logic                tgt_in_range;
    logic                issue;
    logic [7:0]          old_byte;
    logic [7:0]          new_byte;
    logic [CALC_W-1:0]   rd_addr_ext;
    logic [8:0]          per_row_sum;
    logic [5:0]          per_row;
    logic [5:0]          bcnt_inc;
    logic [8:0]          row_inc;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Row multiply for the next data byte, registered at acceptance.
    assign ysum = {1'b0, gy_reg} + {1'b0, row_reg};
    assign prod = 18'(ysum) * 18'(stride_reg);

    // Glyph mask of the current byte: pad bits beyond the width are dropped.
    assign left    = gw_reg - {bcnt_reg, 3'b000};
    assign gmask   = (left >= 8'd8) ? 8'hff : ~(8'hff >> left[2:0]);
    assign dmasked = glyph_byte & gmask;

    // Target of the current slot: slot bit 1 picks the plane, bit 0 the spill.
    assign tgt_base     = idx_reg[1] ? CALC_W'(green_base_reg) : '0;
    assign tgt_addr     = tgt_base + off_reg + CALC_W'(idx_reg[0]);
    assign tgt_mask     = idx_reg[0] ? mask16_reg[7:0] : mask16_reg[15:8];
    assign tgt_data     = idx_reg[0] ? data16_reg[7:0] : data16_reg[15:8];
    assign tgt_en       = planes_reg[idx_reg[1]] && (tgt_mask != 8'h00);
    assign tgt_in_range = (tgt_addr < CALC_W'(FB_BYTES));
    assign issue        = (state_reg == S_RMW) && tgt_en && tgt_in_range;

    // Merge of the pending write, forwarding the last byte written.
    assign old_byte = (lw_valid_reg && (lw_addr_reg == pend_addr_reg)) ? lw_data_reg
                                                                       : ram_rdata;
    assign new_byte = (old_byte & ~pend_mask_reg) | (pend_data_reg & pend_mask_reg);

    assign rd_addr_ext = CALC_W'(read_address);

    // Row and glyph end detection.
    assign per_row_sum = {1'b0, gw_reg} + 9'd7;
    assign per_row     = per_row_sum[8:3];
    assign bcnt_inc    = {1'b0, bcnt_reg} + 6'd1;
    assign row_inc     = {1'b0, row_reg} + 9'd1;

    // RAM port selection: clearing pass or pending masked write.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'h00;
        end
        else
        begin
            ram_we    = pend_valid_reg;
            ram_waddr = pend_addr_reg;
            ram_wdata = new_byte;
        end
        if (state_reg == S_RMW)
        begin
            ram_raddr = tgt_addr[FB_AW-1:0];
        end
        else
        begin
            ram_raddr = rd_addr_ext[FB_AW-1:0];
        end
    end

    // Controller next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        gw_next         = gw_reg;
        gh_next         = gh_reg;
        planes_next     = planes_reg;
        row_next        = row_reg;
        bcnt_next       = bcnt_reg;
        active_next     = active_reg;
        prod_next       = prod_reg;
        data16_next     = data16_reg;
        mask16_next     = mask16_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        err_next        = err_reg;
        rd_ok_next      = rd_ok_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        pend_mask_next  = pend_mask_reg;
        strobe_next     = 1'b0;
        rdata_out_next  = 8'h00;
        done_next       = 1'b0;
        status_next     = ST_OK;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + FB_AW'(1);
                if (clr_reg == FB_AW'(FB_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_START:
                        begin
                            gx_next     = pos_x;
                            gy_next     = pos_y;
                            gw_next     = glyph_width;
                            gh_next     = glyph_height;
                            planes_next = color_planes;
                            row_next    = 8'd0;
                            bcnt_next   = 5'd0;
                            active_next = (glyph_width != 8'd0) && (glyph_height != 8'd0);
                            strobe_next = 1'b1;
                            done_next   = (glyph_width == 8'd0) || (glyph_height == 8'd0);
                        end
                        OP_DATA:
                        begin
                            if (active_reg)
                            begin
                                prod_next   = prod;
                                data16_next = {dmasked, 8'h00} >> gx_reg[2:0];
                                mask16_next = {gmask, 8'h00} >> gx_reg[2:0];
                                err_next    = 1'b0;
                                state_next  = S_ADDR;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_IGNORED;
                            end
                        end
                        OP_READ:
                        begin
                            rd_ok_next = (rd_addr_ext < CALC_W'(FB_BYTES));
                            state_next = S_READ;
                        end
                        OP_NONE:
                        begin
                            strobe_next = 1'b1;
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                strobe_next    = 1'b1;
                rdata_out_next = rd_ok_reg ? ram_rdata : 8'h00;
                state_next     = S_IDLE;
            end

            S_ADDR:
            begin
                off_next   = CALC_W'(prod_reg) + CALC_W'(gx_reg[10:3]) + CALC_W'(bcnt_reg);
                idx_next   = 2'd0;
                state_next = S_RMW;
            end

            S_RMW:
            begin
                // One slot a cycle: issue the read, the write follows next cycle.
                pend_valid_next = issue;
                pend_addr_next  = tgt_addr[FB_AW-1:0];
                pend_data_next  = tgt_data;
                pend_mask_next  = tgt_mask;
                if (tgt_en && !tgt_in_range)
                begin
                    err_next = 1'b1;
                end
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                // The last pending write completes here; advance the glyph.
                strobe_next = 1'b1;
                status_next = err_reg ? ST_DROPPED : ST_OK;
                if (bcnt_inc >= per_row)
                begin
                    bcnt_next = 5'd0;
                    if (row_inc >= {1'b0, gh_reg})
                    begin
                        active_next = 1'b0;
                        row_next    = 8'd0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        row_next = row_inc[7:0];
                    end
                end
                else
                begin
                    bcnt_next = bcnt_inc[4:0];
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            stride_reg     <= STRIDE_RESET;
            green_base_reg <= GREEN_BASE_RESET;
            gx_reg         <= '0;
            gy_reg         <= '0;
            gw_reg         <= '0;
            gh_reg         <= '0;
            planes_reg     <= '0;
            row_reg        <= '0;
            bcnt_reg       <= '0;
            active_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            lw_valid_reg   <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            gx_reg         <= gx_next;
            gy_reg         <= gy_next;
            gw_reg         <= gw_next;
            gh_reg         <= gh_next;
            planes_reg     <= planes_next;
            row_reg        <= row_next;
            bcnt_reg       <= bcnt_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            lw_valid_reg   <= ram_we && (state_reg != S_CLEAR);
            strobe_reg     <= strobe_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_STRIDE)
                begin
                    stride_reg <= cfg_data[8:0];
                end
                else
                begin
                    green_base_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        data16_reg    <= data16_next;
        mask16_reg    <= mask16_next;
        off_reg       <= off_next;
        idx_reg       <= idx_next;
        err_reg       <= err_next;
        rd_ok_reg     <= rd_ok_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        pend_mask_reg <= pend_mask_next;
        lw_addr_reg   <= ram_waddr;
        lw_data_reg   <= ram_wdata;
        rdata_out_reg <= rdata_out_next;
        done_reg      <= done_next;
        status_reg    <= status_next;
    end

    // Frame buffer.
    bagb_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_buffer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result beat.
    assign result_strobe = strobe_reg;
    assign read_data     = rdata_out_reg;
    assign glyph_done    = done_reg;
    assign status        = status_reg;

endmodule

// ----- tb/glyph_blit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_blit_checker: result predictor and comparator for the glyph blitter
// Watches the command, configuration and result ports. It keeps its own
// copy of the frame buffer, the registers and the glyph walk state. Each
// accepted command beat yields one expected result, and each result beat is
// checked against the oldest one still awaited.
// ----------------------------------------------------------------------------
module glyph_blit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [10:0] pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  glyph_width,
    input  logic [7:0]  glyph_height,
    input  logic [1:0]  color_planes,
    input  logic [7:0]  glyph_byte,
    input  logic [12:0] read_address,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        result_strobe,
    input  logic [7:0]  read_data,
    input  logic        glyph_done,
    input  logic [1:0]  status,
    output int          error_count,
    output int          pending
);

    import bagb_pkg::*;

    typedef struct packed {
        logic [7:0] rdata;
        logic       done;
        logic [1:0] st;
    } blit_outcome_t;

    // Shadow frame buffer and registers.
    logic [7:0]  fb_shadow [FB_BYTES];
    logic [8:0]  stride_q;
    logic [12:0] green_base_q;

    // Glyph walk state. Counters are plain integers so that a row of
    // 32 bytes does not wrap.
    logic [10:0] glyph_x_q;
    logic [7:0]  glyph_y_q;
    logic [7:0]  glyph_w_q;
    logic [7:0]  glyph_h_q;
    logic [1:0]  planes_q;
    int          row_idx;
    int          col_idx;
    bit          drawing;

    blit_outcome_t awaited_results[$];

    initial error_count = 0;

    // Masked byte store; an address past the buffer is dropped.
    function automatic bit store_masked(int addr, logic [7:0] data, logic [7:0] mask);
        if (mask == 8'h00)
            return 1'b1;
        if (addr >= FB_BYTES)
            return 1'b0;
        fb_shadow[addr] = (fb_shadow[addr] & ~mask) | (data & mask);
        return 1'b1;
    endfunction

    // Applies the command on the ports to the shadow state and returns the
    // result beat it must produce.
    function automatic blit_outcome_t expected_outcome();
        blit_outcome_t res;
        int            per_row;
        int            left;
        int            nbits;
        int            offset;
        int            addr;
        logic [7:0]    gmask;
        logic [15:0]   data16;
        logic [15:0]   mask16;
        bit            in_range;

        res = '0;
        case (op)
            OP_START:
            begin
                glyph_x_q = pos_x;
                glyph_y_q = pos_y;
                glyph_w_q = glyph_width;
                glyph_h_q = glyph_height;
                planes_q  = color_planes;
                row_idx   = 0;
                col_idx   = 0;
                drawing   = (glyph_width != 8'd0) && (glyph_height != 8'd0);
                res.done  = !drawing;
            end
            OP_DATA:
            begin
                if (!drawing)
                begin
                    res.st = ST_IGNORED;
                end
                else
                begin
                    // Keep only the bits inside the glyph width, then shift
                    // them to the pixel position across two buffer bytes.
                    per_row = (int'(glyph_w_q) + 7) >> 3;
                    left    = int'(glyph_w_q) - 8 * col_idx;
                    nbits   = (left > 8) ? 8 : left;
                    gmask   = 8'hff << (8 - nbits);
                    data16  = {glyph_byte & gmask, 8'h00} >> glyph_x_q[2:0];
                    mask16  = {gmask, 8'h00} >> glyph_x_q[2:0];
                    offset  = (int'(glyph_y_q) + row_idx) * int'(stride_q)
                            + int'(glyph_x_q >> 3) + col_idx;
                    in_range = 1'b1;
                    // Red plane first, then green; the order matters when
                    // the two planes overlap.
                    for (int p = 0; p < 2; p++)
                    begin
                        if (planes_q[p])
                        begin
                            addr = ((p == 0) ? 0 : int'(green_base_q)) + offset;
                            if (!store_masked(addr, data16[15:8], mask16[15:8]))
                                in_range = 1'b0;
                            if (!store_masked(addr + 1, data16[7:0], mask16[7:0]))
                                in_range = 1'b0;
                        end
                    end
                    if (!in_range)
                        res.st = ST_DROPPED;
                    col_idx++;
                    if (col_idx >= per_row)
                    begin
                        col_idx = 0;
                        row_idx++;
                        if (row_idx >= int'(glyph_h_q))
                        begin
                            drawing  = 1'b0;
                            row_idx  = 0;
                            res.done = 1'b1;
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (int'(read_address) < FB_BYTES)
                    res.rdata = fb_shadow[read_address];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Sample everything at the rising edge: registers, result beats, then
    // newly accepted command beats.
    always @(posedge clk or negedge rst_n)
    begin
        blit_outcome_t got;
        blit_outcome_t exp;

        if (!rst_n)
        begin
            for (int i = 0; i < FB_BYTES; i++)
                fb_shadow[i] = 8'h00;
            stride_q     = STRIDE_RESET;
            green_base_q = GREEN_BASE_RESET;
            glyph_x_q    = '0;
            glyph_y_q    = '0;
            glyph_w_q    = '0;
            glyph_h_q    = '0;
            planes_q     = '0;
            row_idx      = 0;
            col_idx      = 0;
            drawing      = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_STRIDE)
                    stride_q = cfg_data[8:0];
                else
                    green_base_q = cfg_data;
            end

            if (result_strobe)
            begin
                got = '{rdata: read_data, done: glyph_done, st: status};
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result beat with none awaited:", $realtime,
                                 " rd=%02h done=%0b st=%0d",
                                 got.rdata, got.done, got.st);
                end
                else
                begin
                    exp = awaited_results.pop_front();
                    if (got.rdata !== exp.rdata || got.done !== exp.done
                        || got.st !== exp.st)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch: expected rd=%02h done=%0b st=%0d",
                                     $realtime, exp.rdata, exp.done, exp.st,
                                     ", got rd=%02h done=%0b st=%0d",
                                     got.rdata, got.done, got.st);
                    end
                end
            end

            if (start && !busy)
                awaited_results.push_back(expected_outcome());
        end
        pending = awaited_results.size();
    end

endmodule

// ----- tb/bit_aligned_glyph_blit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_aligned_glyph_blit_test: top level test of the glyph blitter
// Drives a directed opening and then phases of random glyph traffic under
// several stride and green plane settings and sender idle rates. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module bit_aligned_glyph_blit_test;
    import bagb_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [10:0] x;
        logic [7:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [1:0]  planes;
        logic [7:0]  gbyte;
        logic [12:0] raddr;
    } blit_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = OP_NONE;
    logic [10:0] pos_x = '0;
    logic [7:0]  pos_y = '0;
    logic [7:0]  glyph_width = '0;
    logic [7:0]  glyph_height = '0;
    logic [1:0]  color_planes = '0;
    logic [7:0]  glyph_byte = '0;
    logic [12:0] read_address = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_STRIDE;
    logic [12:0] cfg_data = '0;
    logic        result_strobe;
    logic [7:0]  read_data;
    logic        glyph_done;
    logic [1:0]  status;
    int          check_errors;
    int          results_pending;

    // Sender state shared by the stimulus tasks.
    int          idle_pct = 0;
    int          items_sent = 0;
    int          cur_stride = STRIDE_RESET;
    int          cur_green_base = GREEN_BASE_RESET;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bit_aligned_glyph_blit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .glyph_width   (glyph_width),
        .glyph_height  (glyph_height),
        .color_planes  (color_planes),
        .glyph_byte    (glyph_byte),
        .read_address  (read_address),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .read_data     (read_data),
        .glyph_done    (glyph_done),
        .status        (status)
    );

    glyph_blit_checker blit_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .glyph_width   (glyph_width),
        .glyph_height  (glyph_height),
        .color_planes  (color_planes),
        .glyph_byte    (glyph_byte),
        .read_address  (read_address),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .read_data     (read_data),
        .glyph_done    (glyph_done),
        .status        (status),
        .error_count   (check_errors),
        .pending       (results_pending)
    );

    // A command with every field random; callers override what matters.
    function automatic blit_cmd_t random_cmd(logic [1:0] code);
        blit_cmd_t c;
        c.op     = code;
        c.x      = 11'($urandom_range(2047));
        c.y      = 8'($urandom_range(255));
        c.w      = 8'($urandom_range(255));
        c.h      = 8'($urandom_range(255));
        c.planes = 2'($urandom_range(3));
        c.gbyte  = 8'($urandom_range(255));
        c.raddr  = 13'($urandom_range(8191));
        return c;
    endfunction

    // Presents one command beat, at times with a random idle gap ahead of it, and
    // returns at the falling edge after it was taken.
    task automatic issue(input blit_cmd_t c, input bit counted);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        op           = c.op;
        pos_x        = c.x;
        pos_y        = c.y;
        glyph_width  = c.w;
        glyph_height = c.h;
        color_planes = c.planes;
        glyph_byte   = c.gbyte;
        read_address = c.raddr;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (counted)
            items_sent++;
    endtask

    task automatic start_glyph(int x, int y, int w, int h, logic [1:0] planes);
        blit_cmd_t c;
        c        = random_cmd(OP_START);
        c.x      = 11'(x);
        c.y      = 8'(y);
        c.w      = 8'(w);
        c.h      = 8'(h);
        c.planes = planes;
        issue(c, 1'b1);
    endtask

    task automatic feed_byte(logic [7:0] b, bit counted);
        blit_cmd_t c;
        c       = random_cmd(OP_DATA);
        c.gbyte = b;
        issue(c, counted);
    endtask

    task automatic read_byte(int addr);
        blit_cmd_t c;
        c       = random_cmd(OP_READ);
        c.raddr = 13'(addr);
        issue(c, 1'b1);
    endtask

    // Holds the sender off until every result beat has come back.
    task automatic settle();
        start = 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // One chunk of random traffic: mostly a whole glyph, sometimes noise.
    task automatic random_traffic();
        int         r;
        int         w;
        int         h;
        int         x;
        int         y;
        int         per_row;
        int         i;
        int         k;
        logic [1:0] planes;
        logic [7:0] b;

        r = $urandom_range(99);
        if (r < 4)
        begin
            // Data beat with no glyph in progress, or a stray one mid-glyph.
            feed_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        if (r < 7)
        begin
            if ($urandom_range(1))
                read_byte($urandom_range(8191));
            else
                issue(random_cmd(OP_NONE), 1'b1);
            return;
        end
        if (r < 8)
        begin
            settle();
            return;
        end

        // Shape: mostly small, a few tall, wide or empty glyphs.
        k = $urandom_range(99);
        if (k < 2)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(100, 255);
        end
        else if (k < 7)
        begin
            w = $urandom_range(200, 255);
            h = $urandom_range(1, 2);
        end
        else if (k < 11)
        begin
            w = $urandom_range(1) ? 0 : $urandom_range(255);
            h = (w == 0) ? $urandom_range(255) : 0;
        end
        else
        begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 4);
        end
        x = $urandom_range(1) ? $urandom_range(2047) : $urandom_range(127);
        y = $urandom_range(1) ? $urandom_range(255) : $urandom_range(31);
        planes = 2'($urandom_range(3));
        start_glyph(x, y, w, h, planes);
        if (w == 0 || h == 0)
            return;

        per_row = (w + 7) / 8;
        for (i = 0; i < per_row * h; i++)
        begin
            k = $urandom_range(99);
            // Abandon the glyph now and then; a later start restarts.
            if (k < 2)
                return;
            if (k < 6)
            begin
                if ($urandom_range(1))
                    read_byte($urandom_range(8191));
                else
                    issue(random_cmd(OP_NONE), 1'b1);
            end
            if ($urandom_range(3) == 0)
                b = $urandom_range(1) ? 8'hff : 8'h00;
            else
                b = 8'($urandom_range(255));
            feed_byte(b, 1'b1);
        end

        // Read back a few bytes of the area just drawn.
        repeat ($urandom_range(0, 3))
            read_byte(($urandom_range(1) ? cur_green_base : 0)
                      + (y + $urandom_range(h - 1)) * cur_stride
                      + x / 8 + $urandom_range(per_row));
    endtask

    // Overall time limit.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int         phase_end;
        int         stride;
        int         gbase;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening at the reset register values.
        read_byte(0);
        read_byte(8191);
        issue(random_cmd(OP_NONE), 1'b1);
        feed_byte(8'ha5, 1'b0);
        start_glyph(5, 5, 0, 5, 2'b11);
        start_glyph(5, 5, 9, 0, 2'b11);
        // Shifted two-byte rows with pad bits set in the last byte.
        start_glyph(3, 1, 10, 2, 2'b11);
        feed_byte(8'hff, 1'b1);
        feed_byte(8'hff, 1'b1);
        feed_byte(8'h00, 1'b1);
        feed_byte(8'hc0, 1'b1);
        read_byte(16);
        read_byte(17);
        read_byte(GREEN_BASE_RESET + 33);
        // Byte aligned: the spill byte stays untouched.
        start_glyph(8, 0, 5, 1, 2'b01);
        feed_byte(8'hff, 1'b1);
        // Restart mid-glyph, then a far corner with green past the buffer.
        start_glyph(0, 0, 8, 1, 2'b10);
        start_glyph(2047, 255, 8, 1, 2'b11);
        feed_byte(8'h00, 1'b1);
        read_byte(4335);
        read_byte(4336);
        // No plane selected: the glyph advances but writes nothing.
        start_glyph(0, 0, 8, 1, 2'b00);
        feed_byte(8'h5a, 1'b1);
        read_byte(0);

        // Random phases, each under its own register setting and idle rate.
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                1:       begin stride = 1;   gbase = 0;    idle_pct = 47; end
                2:       begin stride = 256; gbase = 8191; idle_pct = 35; end
                3:       begin stride = 0;   gbase = 2048; idle_pct = 0;  end
                4:       begin stride = 511; gbase = 100;  idle_pct = 47; end
                5:
                begin
                    stride   = $urandom_range(1, 256);
                    gbase    = $urandom_range(8191);
                    idle_pct = 35;
                end
                default: begin stride = STRIDE_RESET; gbase = GREEN_BASE_RESET; idle_pct = 0; end
            endcase
            if (ph > 0)
            begin
                write_reg(REG_STRIDE, {4'($urandom_range(15)), 9'(stride)});
                write_reg(REG_GREEN_BASE, 13'(gbase));
                cur_stride     = stride;
                cur_green_base = gbase;
            end
            phase_end = items_sent + 150;
            while (items_sent < phase_end)
                random_traffic();
        end

        settle();
        repeat (10) @(negedge clk);
        if (check_errors == 0 && results_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- bit_aligned_glyph_blit.f -----
hdl/bagb_pkg.sv
hdl/bagb_ram.sv
hdl/bit_aligned_glyph_blit.sv
tb/glyph_blit_checker.sv
tb/bit_aligned_glyph_blit_test.sv
